[hdl/assert_macros.svh]
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every rising clock edge outside reset.
`define MSH_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define MSH_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define MSH_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

[hdl/msh_pkg.sv]
// Types, constants and helper functions of the magnetometer smoothing block.
package msh_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int ANGLE_STEPS  = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NUM_STEPS    = (ANGLE_STEPS > TABLE_LEN) ? TABLE_LEN : ANGLE_STEPS;
  localparam int STEP_W       = $clog2(TABLE_LEN);

  localparam int HEAD_W       = 17;
  localparam int HEAD_MAX     = 46080;
  localparam int WEIGHT_W     = 17;
  localparam int FRAC_BITS    = 16;
  localparam logic [WEIGHT_W-1:0] ONE_Q16      = WEIGHT_W'(65536);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(52429);

  // CORDIC vector width leaves room for the quadrant negation and the gain.
  localparam int CW = SAMPLE_WIDTH + 3;
  // Angle accumulator in degrees times 65536.
  localparam int ZW = 26;
  localparam int ZR_W = ZW - 8;
  localparam int QUARTER_TURN = 90 * 65536;

  // Blend datapath widths.
  localparam int BW   = (SAMPLE_WIDTH > HEAD_W) ? SAMPLE_WIDTH : HEAD_W;
  localparam int DW   = BW + 1;
  localparam int WW   = WEIGHT_W + 1;
  localparam int PW   = DW + WW;
  localparam int SUMW = PW + 1;

  // Blend lanes: three axes, then the heading.
  localparam int LANE_W = 3;
  localparam logic [LANE_W-1:0] LANE_X    = LANE_W'(0);
  localparam logic [LANE_W-1:0] LANE_Y    = LANE_W'(1);
  localparam logic [LANE_W-1:0] LANE_Z    = LANE_W'(2);
  localparam logic [LANE_W-1:0] LANE_HEAD = LANE_W'(3);
  localparam logic [LANE_W-1:0] LANE_END  = LANE_W'(4);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_WEIGHT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_KEEP = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUAD,
    ST_CORDIC,
    ST_ROUND,
    ST_BLEND,
    ST_DONE
  } msh_state_t;

  // atan(2^-i) in degrees times 65536, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] val;
    case (idx)
      5'd0:    val = ZW'(2949120);
      5'd1:    val = ZW'(1740967);
      5'd2:    val = ZW'(919879);
      5'd3:    val = ZW'(466945);
      5'd4:    val = ZW'(234379);
      5'd5:    val = ZW'(117304);
      5'd6:    val = ZW'(58666);
      5'd7:    val = ZW'(29335);
      5'd8:    val = ZW'(14668);
      5'd9:    val = ZW'(7334);
      5'd10:   val = ZW'(3667);
      5'd11:   val = ZW'(1833);
      5'd12:   val = ZW'(917);
      5'd13:   val = ZW'(458);
      5'd14:   val = ZW'(229);
      5'd15:   val = ZW'(115);
      5'd16:   val = ZW'(57);
      5'd17:   val = ZW'(29);
      5'd18:   val = ZW'(14);
      5'd19:   val = ZW'(7);
      5'd20:   val = ZW'(4);
      5'd21:   val = ZW'(2);
      5'd22:   val = ZW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

  // A weight above one counts as one.
  function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [WEIGHT_W-1:0] w);
    return (w > ONE_Q16) ? ONE_Q16 : w;
  endfunction

endpackage

[hdl/msh_sample_if.sv]
// Channel carrying one three-axis magnetometer sample per transaction.
interface msh_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [msh_pkg::SAMPLE_WIDTH-1:0] field_x;
  logic signed [msh_pkg::SAMPLE_WIDTH-1:0] field_y;
  logic signed [msh_pkg::SAMPLE_WIDTH-1:0] field_z;
  logic                                  first_sample;

  modport source (output valid, field_x, field_y, field_z, first_sample, input ready);
  modport sink   (input valid, field_x, field_y, field_z, first_sample, output ready);
endinterface

[hdl/msh_result_if.sv]
// Channel carrying the smoothed field and heading, one result per transaction.
interface msh_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [msh_pkg::SAMPLE_WIDTH-1:0] smooth_x;
  logic signed [msh_pkg::SAMPLE_WIDTH-1:0] smooth_y;
  logic signed [msh_pkg::SAMPLE_WIDTH-1:0] smooth_z;
  logic signed [msh_pkg::HEAD_W-1:0]       heading;

  modport source (output valid, smooth_x, smooth_y, smooth_z, heading, input ready);
  modport sink   (input valid, smooth_x, smooth_y, smooth_z, heading, output ready);
endinterface

[hdl/msh_config_if.sv]
// Register write channel: one register index and its data per transaction.
interface msh_config_if;
  logic                             valid;
  logic                             ready;
  logic [msh_pkg::CFG_IDX_W-1:0]    index;
  logic [msh_pkg::WEIGHT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/magnetometer_smoothing_heading_unit.sv]
// Magnetometer smoothing with CORDIC heading: sequencer, CORDIC and blend datapath.
// It takes no new sample until the last result is in the output register; the 16 iterations
// of the shift-add CORDIC unit and the four passes through the single blend multiplier
// make up most of the work on each sample.
// Reset (synchronous, rst high): weights return to 0.8, the averages are cleared and
// the next sample loads the state directly; register writes are taken every cycle.
`include "assert_macros.svh"

module magnetometer_smoothing_heading_unit (
  input  logic          clk,
  input  logic          rst,
  msh_sample_if.sink    mag,
  msh_config_if.sink    cfg,
  msh_result_if.source  smooth
);

  msh_pkg::msh_state_t state, state_next;

  // Sequencer controls.
  logic ready_c, capture_c, quad_c, step_c, round_c, blend_c, emit_c;

  // Configuration.
  logic [msh_pkg::WEIGHT_W-1:0] axis_weight, heading_keep_weight;

  // Captured sample.
  logic signed [msh_pkg::SAMPLE_WIDTH-1:0] nx, ny, nz;
  logic load, primed;

  // CORDIC.
  logic signed [msh_pkg::CW-1:0] cx, cy, xs, ys;
  logic signed [msh_pkg::ZW-1:0] cz;
  logic signed [msh_pkg::ZR_W-1:0] zr;
  logic [msh_pkg::STEP_W-1:0] step;
  logic zero_vec;
  logic signed [msh_pkg::HEAD_W-1:0] nh;

  // Smoothed state.
  logic signed [msh_pkg::SAMPLE_WIDTH-1:0] avg_x, avg_y, avg_z;
  logic signed [msh_pkg::HEAD_W-1:0] avg_heading;

  // Blend pipeline.
  logic [msh_pkg::LANE_W-1:0] lane;
  logic signed [msh_pkg::BW-1:0] op_a, op_b, a_hold, b_hold;
  logic [msh_pkg::WEIGHT_W-1:0] op_w;
  logic signed [msh_pkg::DW-1:0] diff;
  logic signed [msh_pkg::WW-1:0] w_s;
  logic signed [msh_pkg::PW-1:0] prod;
  logic signed [msh_pkg::SUMW-1:0] sum, sum_adj;
  logic signed [msh_pkg::BW-1:0] blended, lane_res;

  // Output register.
  logic out_valid;
  logic signed [msh_pkg::SAMPLE_WIDTH-1:0] out_x, out_y, out_z;
  logic signed [msh_pkg::HEAD_W-1:0] out_heading;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      msh_pkg::ST_IDLE:   if (mag.valid) state_next = msh_pkg::ST_QUAD;
      msh_pkg::ST_QUAD:   state_next = msh_pkg::ST_CORDIC;
      msh_pkg::ST_CORDIC: if (step == msh_pkg::STEP_W'(msh_pkg::NUM_STEPS - 1)) begin
        state_next = msh_pkg::ST_ROUND;
      end
      msh_pkg::ST_ROUND:  state_next = msh_pkg::ST_BLEND;
      msh_pkg::ST_BLEND:  if (lane == msh_pkg::LANE_END) state_next = msh_pkg::ST_DONE;
      msh_pkg::ST_DONE:   if (!out_valid || smooth.ready) state_next = msh_pkg::ST_IDLE;
      default:            state_next = msh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ready_c   = 1'b0;
    quad_c    = 1'b0;
    step_c    = 1'b0;
    round_c   = 1'b0;
    blend_c   = 1'b0;
    emit_c    = 1'b0;
    case (state)
      msh_pkg::ST_IDLE:   ready_c = 1'b1;
      msh_pkg::ST_QUAD:   quad_c  = 1'b1;
      msh_pkg::ST_CORDIC: step_c  = 1'b1;
      msh_pkg::ST_ROUND:  round_c = 1'b1;
      msh_pkg::ST_BLEND:  blend_c = 1'b1;
      msh_pkg::ST_DONE:   emit_c  = !out_valid || smooth.ready;
      default: ;
    endcase
    capture_c = ready_c && mag.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign mag.ready = ready_c;

  // ----------------------------------------------------------- configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_weight         <= msh_pkg::WEIGHT_RESET;
      heading_keep_weight <= msh_pkg::WEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        msh_pkg::CFG_AXIS_WEIGHT:  axis_weight         <= msh_pkg::clamp_weight(cfg.data);
        msh_pkg::CFG_HEADING_KEEP: heading_keep_weight <= msh_pkg::clamp_weight(cfg.data);
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ capture
  always_ff @(posedge clk) begin
    if (capture_c) begin
      nx   <= mag.field_x;
      ny   <= mag.field_y;
      nz   <= mag.field_z;
      load <= mag.first_sample || !primed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (emit_c) begin
      primed <= 1'b1;
    end
  end

  // ------------------------------------------------------------ CORDIC
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign zr = msh_pkg::ZR_W'((cz + msh_pkg::ZW'(128)) >>> 8);

  always_ff @(posedge clk) begin
    if (quad_c) begin
      step     <= '0;
      zero_vec <= (nx == '0) && (ny == '0);
      // Bring the vector into the right half plane first.
      if (nx < 0 && ny >= 0) begin
        cx <= msh_pkg::CW'(ny);
        cy <= -msh_pkg::CW'(nx);
        cz <= msh_pkg::ZW'(msh_pkg::QUARTER_TURN);
      end else if (nx < 0) begin
        cx <= -msh_pkg::CW'(ny);
        cy <= msh_pkg::CW'(nx);
        cz <= -msh_pkg::ZW'(msh_pkg::QUARTER_TURN);
      end else begin
        cx <= msh_pkg::CW'(nx);
        cy <= msh_pkg::CW'(ny);
        cz <= '0;
      end
    end else if (step_c) begin
      step <= step + 1'b1;
      if (!cy[msh_pkg::CW-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + msh_pkg::atan_entry(step);
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - msh_pkg::atan_entry(step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (round_c) begin
      if (zero_vec) begin
        nh <= '0;
      end else if (zr > msh_pkg::HEAD_MAX) begin
        nh <= msh_pkg::HEAD_W'(msh_pkg::HEAD_MAX);
      end else if (zr < -msh_pkg::HEAD_MAX) begin
        nh <= -msh_pkg::HEAD_W'(msh_pkg::HEAD_MAX);
      end else begin
        nh <= msh_pkg::HEAD_W'(zr);
      end
    end
  end

  // ------------------------------------------------------------ blend
  // Each lane computes b + (a - b) * w / 2^16 as ((a - b) * w + b * 2^16) / 2^16,
  // truncated toward zero. The multiply of one lane overlaps the finish of the
  // lane before it.
  always_comb begin
    case (lane)
      msh_pkg::LANE_X: begin
        op_a = msh_pkg::BW'(nx);
        op_b = msh_pkg::BW'(avg_x);
        op_w = axis_weight;
      end
      msh_pkg::LANE_Y: begin
        op_a = msh_pkg::BW'(ny);
        op_b = msh_pkg::BW'(avg_y);
        op_w = axis_weight;
      end
      msh_pkg::LANE_Z: begin
        op_a = msh_pkg::BW'(nz);
        op_b = msh_pkg::BW'(avg_z);
        op_w = axis_weight;
      end
      msh_pkg::LANE_HEAD: begin
        op_a = msh_pkg::BW'(avg_heading);
        op_b = msh_pkg::BW'(nh);
        op_w = heading_keep_weight;
      end
      default: begin
        op_a = '0;
        op_b = '0;
        op_w = '0;
      end
    endcase
  end

  assign diff    = msh_pkg::DW'(op_a) - msh_pkg::DW'(op_b);
  assign w_s     = $signed({1'b0, op_w});
  assign sum     = msh_pkg::SUMW'(prod)
                 + (msh_pkg::SUMW'(b_hold) <<< msh_pkg::FRAC_BITS);
  assign sum_adj = sum[msh_pkg::SUMW-1]
                 ? sum + msh_pkg::SUMW'((1 << msh_pkg::FRAC_BITS) - 1) : sum;
  assign blended = msh_pkg::BW'(sum_adj >>> msh_pkg::FRAC_BITS);

  // A loading item takes the new sample and the new heading as they are.
  always_comb begin
    if (!load) begin
      lane_res = blended;
    end else if (lane == msh_pkg::LANE_END) begin
      lane_res = b_hold;
    end else begin
      lane_res = a_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (round_c) begin
      lane <= '0;
    end else if (blend_c) begin
      lane   <= lane + 1'b1;
      prod   <= diff * w_s;
      a_hold <= op_a;
      b_hold <= op_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_x       <= '0;
      avg_y       <= '0;
      avg_z       <= '0;
      avg_heading <= '0;
    end else if (blend_c) begin
      case (lane)
        msh_pkg::LANE_Y:    avg_x       <= msh_pkg::SAMPLE_WIDTH'(lane_res);
        msh_pkg::LANE_Z:    avg_y       <= msh_pkg::SAMPLE_WIDTH'(lane_res);
        msh_pkg::LANE_HEAD: avg_z       <= msh_pkg::SAMPLE_WIDTH'(lane_res);
        msh_pkg::LANE_END:  avg_heading <= msh_pkg::HEAD_W'(lane_res);
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_c) begin
      out_valid <= 1'b1;
    end else if (smooth.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_c) begin
      out_x       <= avg_x;
      out_y       <= avg_y;
      out_z       <= avg_z;
      out_heading <= avg_heading;
    end
  end

  assign smooth.valid    = out_valid;
  assign smooth.smooth_x = out_x;
  assign smooth.smooth_y = out_y;
  assign smooth.smooth_z = out_z;
  assign smooth.heading  = out_heading;

  // ------------------------------------------------------------ checks
  `MSH_ASSERT_NEXT(busy_after_sample, mag.valid && mag.ready, !mag.ready, "sample taken while busy")
  `MSH_ASSERT_SAME(step_in_range, state == msh_pkg::ST_CORDIC, step < msh_pkg::STEP_W'(msh_pkg::NUM_STEPS), "CORDIC step out of range")
  `MSH_ASSERT_SAME(heading_in_range, smooth.valid, (smooth.heading <= msh_pkg::HEAD_MAX) && (smooth.heading >= -msh_pkg::HEAD_MAX), "heading outside +-180 degrees")
  `MSH_ASSERT_SAME(blend_lane_bound, state == msh_pkg::ST_BLEND, lane <= msh_pkg::LANE_END, "blend lane past heading")

endmodule

[bench/tb_magnetometer_smoothing_heading_unit.sv]
// Self-checking bench for the magnetometer smoothing and heading unit.
module tb_magnetometer_smoothing_heading_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SW         = msh_pkg::SAMPLE_WIDTH;
  localparam int     SAMPLE_MIN = -(2 ** (SW - 1));
  localparam int     SAMPLE_MAX = (2 ** (SW - 1)) - 1;
  localparam longint UNITY      = 65536;
  localparam int     SETTLE     = 40;
  localparam int     LIMIT      = 400000;
  localparam int     PHASE_ITEMS = 125;
  localparam int     PHASES      = 8;

  // atan(2^-i) in degrees times 65536.
  localparam longint ATAN_DEG16 [msh_pkg::TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
    logic                 first;
  } mag_sample_t;

  typedef struct {
    logic signed [SW-1:0]              smooth_x;
    logic signed [SW-1:0]              smooth_y;
    logic signed [SW-1:0]              smooth_z;
    logic signed [msh_pkg::HEAD_W-1:0] heading;
  } smooth_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WEIGHTS} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    mag_sample_t                   smp;
    bit                            known;
    smooth_result_t                res;
    logic [msh_pkg::WEIGHT_W-1:0]  wa;
    logic [msh_pkg::WEIGHT_W-1:0]  wd;
  } stim_row_t;

  logic clk;
  logic rst;

  msh_sample_if mag ();
  msh_config_if cfg ();
  msh_result_if smooth ();

  magnetometer_smoothing_heading_unit uut (
    .clk    (clk),
    .rst    (rst),
    .mag    (mag),
    .cfg    (cfg),
    .smooth (smooth)
  );

  // Predicted state of the block.
  longint est_x, est_y, est_z, est_heading;
  bit     est_primed;
  longint axis_w, keep_w;

  smooth_result_t pending_smooth [$];
  stim_row_t      directed_rows [$];
  smooth_result_t no_result;
  smooth_result_t got_want;
  int             idle_pct;
  int             errors;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("magnetometer_smoothing_heading_unit regression: fail");
    $finish;
  end

  function automatic longint cordic_angle(input longint xi, input longint yi);
    longint x, y, z, t, xs, ys;
    int     i;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // Fold the left half plane into the right one first.
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * UNITY;
      end else begin
        t = x; x = -y; y = t; z = -90 * UNITY;
      end
    end
    for (i = 0; i < msh_pkg::NUM_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_DEG16[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_DEG16[i];
      end
    end
    z = (z + 128) >>> 8;
    if (z > msh_pkg::HEAD_MAX) z = msh_pkg::HEAD_MAX;
    if (z < -msh_pkg::HEAD_MAX) z = -msh_pkg::HEAD_MAX;
    return z;
  endfunction

  function automatic longint limit_weight(input longint w);
    return (w > UNITY) ? UNITY : w;
  endfunction

  // Weighted mean with truncation toward zero.
  function automatic longint mix(input longint a, input longint b, input longint wa);
    return (a * wa + b * (UNITY - wa)) / UNITY;
  endfunction

  function automatic smooth_result_t smooth_predict(input mag_sample_t s);
    longint         nx, ny, nz, nh, a, d;
    smooth_result_t r;
    nx = s.x;
    ny = s.y;
    nz = s.z;
    nh = cordic_angle(nx, ny);
    if (s.first || !est_primed) begin
      est_x = nx; est_y = ny; est_z = nz; est_heading = nh;
    end else begin
      a = limit_weight(axis_w);
      d = limit_weight(keep_w);
      est_x = mix(nx, est_x, a);
      est_y = mix(ny, est_y, a);
      est_z = mix(nz, est_z, a);
      est_heading = mix(est_heading, nh, d);
    end
    est_primed = 1'b1;
    r.smooth_x = SW'(est_x);
    r.smooth_y = SW'(est_y);
    r.smooth_z = SW'(est_z);
    r.heading  = msh_pkg::HEAD_W'(est_heading);
    return r;
  endfunction

  function automatic mag_sample_t make_sample(input int x, input int y, input int z,
                                              input bit first);
    mag_sample_t s;
    s.x = SW'(x);
    s.y = SW'(y);
    s.z = SW'(z);
    s.first = first;
    return s;
  endfunction

  function automatic void directed_sample(input int x, input int y, input int z,
                                          input bit first);
    stim_row_t r;
    r.kind  = ROW_SAMPLE;
    r.smp   = make_sample(x, y, z, first);
    r.known = 1'b0;
    r.res   = no_result;
    r.wa    = '0;
    r.wd    = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void directed_known(input int x, input int y, input int z, input bit first,
                                         input int ex, input int ey, input int ez,
                                         input int eh);
    stim_row_t r;
    r.kind  = ROW_SAMPLE;
    r.smp   = make_sample(x, y, z, first);
    r.known = 1'b1;
    r.res.smooth_x = SW'(ex);
    r.res.smooth_y = SW'(ey);
    r.res.smooth_z = SW'(ez);
    r.res.heading  = msh_pkg::HEAD_W'(eh);
    r.wa    = '0;
    r.wd    = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void directed_weights(input int wa, input int wd);
    stim_row_t r;
    r.kind  = ROW_WEIGHTS;
    r.smp   = make_sample(0, 0, 0, 1'b0);
    r.known = 1'b0;
    r.res   = no_result;
    r.wa    = msh_pkg::WEIGHT_W'(wa);
    r.wd    = msh_pkg::WEIGHT_W'(wd);
    directed_rows.push_back(r);
  endfunction

  function automatic logic signed [SW-1:0] random_field();
    int v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return SW'($urandom());
      4: v = int'($urandom_range(0, 32)) - 16;
      5: v = int'($urandom_range(0, 8191)) - 4096;
      6: begin
        case ($urandom_range(0, 3))
          0: v = SAMPLE_MIN;
          1: v = SAMPLE_MAX;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 2000000)) - 1000000;
    endcase
    return SW'(v);
  endfunction

  function automatic mag_sample_t random_sample();
    mag_sample_t s;
    s.x = random_field();
    s.y = random_field();
    s.z = random_field();
    // Land on the axes now and then, where the quadrant fold has its edges.
    case ($urandom_range(0, 9))
      0: s.y = '0;
      1: s.x = '0;
      default: ;
    endcase
    s.first = ($urandom_range(0, 19) == 0);
    return s;
  endfunction

  function automatic logic [msh_pkg::WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return msh_pkg::ONE_Q16;
      2: return msh_pkg::WEIGHT_W'(65537 + $urandom_range(0, 65534));
      3: return msh_pkg::WEIGHT_W'($urandom_range(0, 65536));
      4: return msh_pkg::WEIGHT_RESET;
      default: return '1;
    endcase
  endfunction

  task automatic send_sample(input mag_sample_t s, input bit known, input smooth_result_t res);
    smooth_result_t want;
    while ($urandom_range(0, 99) < idle_pct) begin
      mag.valid <= 1'b0;
      @(posedge clk);
    end
    mag.valid        <= 1'b1;
    mag.field_x      <= s.x;
    mag.field_y      <= s.y;
    mag.field_z      <= s.z;
    mag.first_sample <= s.first;
    @(posedge clk);
    while (!mag.ready) @(posedge clk);
    // The predictor runs for every transaction so its state tracks the block.
    want = smooth_predict(s);
    pending_smooth.push_back(known ? res : want);
  endtask

  task automatic set_weights(input logic [msh_pkg::WEIGHT_W-1:0] wa,
                             input logic [msh_pkg::WEIGHT_W-1:0] wd);
    cfg.valid <= 1'b1;
    cfg.index <= msh_pkg::CFG_AXIS_WEIGHT;
    cfg.data  <= wa;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.index <= msh_pkg::CFG_HEADING_KEEP;
    cfg.data  <= wd;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    axis_w = wa;
    keep_w = wd;
  endtask

  task automatic wait_drained();
    mag.valid <= 1'b0;
    while (pending_smooth.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      smooth.ready <= 1'b0;
    end else begin
      if (smooth.valid && smooth.ready) begin
        if (pending_smooth.size() == 0) begin
          $error("result transaction with no expectation pending");
          errors++;
        end else begin
          got_want = pending_smooth.pop_front();
          check_field("smooth_x", got_want.smooth_x, smooth.smooth_x);
          check_field("smooth_y", got_want.smooth_y, smooth.smooth_y);
          check_field("smooth_z", got_want.smooth_z, smooth.smooth_z);
          check_field("heading", got_want.heading, smooth.heading);
        end
      end
      smooth.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  initial begin
    int phase;
    rst              = 1'b1;
    mag.valid        = 1'b0;
    mag.field_x      = '0;
    mag.field_y      = '0;
    mag.field_z      = '0;
    mag.first_sample = 1'b0;
    cfg.valid        = 1'b0;
    cfg.index        = msh_pkg::CFG_AXIS_WEIGHT;
    cfg.data         = '0;
    no_result        = '{default: '0};
    errors           = 0;
    idle_pct         = 10;
    est_x = 0; est_y = 0; est_z = 0; est_heading = 0;
    est_primed = 1'b0;
    axis_w = msh_pkg::WEIGHT_RESET;
    keep_w = msh_pkg::WEIGHT_RESET;

    // The first sample after reset loads directly even without first_sample.
    directed_known(0, 0, 0, 1'b0, 0, 0, 0, 0);
    directed_known(0, 0, SAMPLE_MIN, 1'b1, 0, 0, SAMPLE_MIN, 0);
    directed_known(0, 0, SAMPLE_MAX, 1'b1, 0, 0, SAMPLE_MAX, 0);
    directed_sample(-100, 0, 5, 1'b1);
    directed_sample(SAMPLE_MAX, SAMPLE_MAX, 0, 1'b0);
    directed_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    directed_sample(SAMPLE_MIN, SAMPLE_MAX, 0, 1'b1);
    directed_sample(SAMPLE_MAX, SAMPLE_MIN, 1, 1'b0);
    directed_sample(1, 1, 1, 1'b0);
    directed_sample(0, -1, 0, 1'b0);
    directed_sample(5000, -7000, 123, 1'b0);
    // Full weight on the new axis sample and on the old heading.
    directed_weights(65536, 65536);
    directed_known(0, 0, 0, 1'b1, 0, 0, 0, 0);
    directed_known(1000, 0, 0, 1'b0, 1000, 0, 0, 0);
    directed_known(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0,
                   SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 0);
    // Weights above one behave as one.
    directed_weights(131071, 131071);
    directed_known(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0,
                   SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 0);
    directed_weights(0, 0);
    directed_sample(123, -456, 789, 1'b0);
    directed_sample(SAMPLE_MAX, 0, 0, 1'b0);
    directed_weights(52429, 52429);
    directed_sample(-3000, 4000, 0, 1'b0);
    directed_sample(0, 3000, -1, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WEIGHTS) begin
        wait_drained();
        set_weights(directed_rows[i].wa, directed_rows[i].wd);
      end else begin
        send_sample(directed_rows[i].smp, directed_rows[i].known, directed_rows[i].res);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: set_weights('0, msh_pkg::ONE_Q16);
        1: set_weights(msh_pkg::ONE_Q16, '0);
        default: set_weights(random_weight(), random_weight());
      endcase
      // One phase runs with both sides streaming back to back.
      idle_pct = (phase == 3) ? 0 : 10;
      repeat (PHASE_ITEMS) send_sample(random_sample(), 1'b0, no_result);
    end

    wait_drained();
    if (errors == 0) begin
      $display("magnetometer_smoothing_heading_unit regression: pass");
    end else begin
      $display("magnetometer_smoothing_heading_unit regression: fail");
    end
    $finish;
  end

endmodule
